// ===== src/rid_pkg.sv =====
package rid_pkg;

  // Fixed field widths.
  localparam int VALUE_W   = 64;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 8;
  localparam int SYMBOLS   = 16;
  localparam int RADIX_W   = 5;
  localparam int CFG_IDX_W = 2;

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_STEP,
    OP_STORE,
    OP_RD_INIT,
    OP_READ,
    OP_EMIT
  } op_e;

  // Datapath flags tested by conditional jumps.
  typedef struct packed {
    logic quot_zero;
    logic count_last;
    logic chunk_last;
    logic ptr_zero;
  } stat_t;

endpackage

// ===== src/rid_ctrl.sv =====
module rid_ctrl
  import rid_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output op_e   op_o,
  output logic  busy
);

  typedef enum logic [2:0] {
    C_NONE,
    C_START,
    C_CHUNK_LAST,
    C_DIGIT_MORE,
    C_PTR_ZERO
  } cond_e;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t nxt_t;
    step_t nxt_f;
  } uword_t;

  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_DIV_STEP = 3'd1;
  localparam step_t ST_STORE    = 3'd2;
  localparam step_t ST_RD_INIT  = 3'd3;
  localparam step_t ST_READ     = 3'd4;
  localparam step_t ST_EMIT     = 3'd5;

  // Microprogram: one word per step, with a target for each branch outcome.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:     w = '{OP_LOAD,     C_START,      ST_DIV_STEP, ST_IDLE};
      ST_DIV_STEP: w = '{OP_DIV_STEP, C_CHUNK_LAST, ST_STORE,    ST_DIV_STEP};
      ST_STORE:    w = '{OP_STORE,    C_DIGIT_MORE, ST_DIV_STEP, ST_RD_INIT};
      ST_RD_INIT:  w = '{OP_RD_INIT,  C_NONE,       ST_READ,     ST_READ};
      ST_READ:     w = '{OP_READ,     C_NONE,       ST_EMIT,     ST_EMIT};
      ST_EMIT:     w = '{OP_EMIT,     C_PTR_ZERO,   ST_IDLE,     ST_READ};
      default:     w = '{OP_NOP,      C_NONE,       ST_IDLE,     ST_IDLE};
    endcase
    return w;
  endfunction

  step_t  upc_q, upc_d;
  uword_t word;
  logic   taken;

  assign word = ucode(upc_q);

  // Evaluate the branch condition of the current word.
  always_comb begin
    unique case (word.cond)
      C_NONE:       taken = 1'b0;
      C_START:      taken = start;
      C_CHUNK_LAST: taken = stat_i.chunk_last;
      C_DIGIT_MORE: taken = !stat_i.quot_zero && !stat_i.count_last;
      C_PTR_ZERO:   taken = stat_i.ptr_zero;
      default:      taken = 1'b0;
    endcase
  end

  assign upc_d = taken ? word.nxt_t : word.nxt_f;

  // A step that waits for start does nothing until the item arrives.
  assign op_o = (word.cond == C_START && !start) ? OP_NOP : word.op;
  assign busy = (upc_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== src/rid_datapath.sv =====
module rid_datapath
  import rid_pkg::*;
#(
  parameter int MAX_DIGITS = 64,
  parameter int MAX_RADIX  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  op_e                        op_i,
  input  logic [VALUE_W-1:0]         value_i,
  input  logic [$clog2(MAX_RADIX+1)-1:0] base_i,
  input  logic [SYMBOLS*CHAR_W-1:0]  symbols_i,
  output stat_t                      stat_o,
  output logic                       digit_valid_o,
  output logic [CHAR_W-1:0]          digit_char_o,
  output logic                       last_o
);

  localparam int REM_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic [VALUE_W-1:0]   quot_q, quot_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] chunk_q;
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     ptr_q;
  logic [DIGIT_W-1:0]   rd_digit_q;
  logic [DIGIT_W-1:0]   mem [MAX_DIGITS];
  logic                 valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;

  // Restoring division: eight quotient bits enter per cycle, MSB first.
  always_comb begin
    logic [REM_W:0]             trial;
    logic [REM_W:0]             base_ext;
    logic [REM_W-1:0]           rem;
    logic [BITS_PER_STEP-1:0]   qbits;
    base_ext = (REM_W + 1)'(base_i);
    rem      = rem_q;
    qbits    = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {rem, quot_q[VALUE_W-1-i]};
      if (trial >= base_ext) begin
        rem                       = REM_W'(trial - base_ext);
        qbits[BITS_PER_STEP-1-i]  = 1'b1;
      end else begin
        rem = trial[REM_W-1:0];
      end
    end
    rem_d  = rem;
    quot_d = {quot_q[VALUE_W-BITS_PER_STEP-1:0], qbits};
  end

  assign stat_o.quot_zero  = (quot_q == '0);
  assign stat_o.count_last = (count_q == CNT_W'(MAX_DIGITS - 1));
  assign stat_o.chunk_last = (chunk_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat_o.ptr_zero   = (ptr_q == '0);

  // Control registers: counters and the output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (op_i == OP_EMIT);
      unique case (op_i)
        OP_LOAD: begin
          chunk_q <= '0;
          count_q <= '0;
        end
        OP_DIV_STEP: chunk_q <= chunk_q + 1'b1;
        OP_STORE: begin
          chunk_q <= '0;
          count_q <= count_q + 1'b1;
        end
        OP_RD_INIT: ptr_q <= IDX_W'(count_q - 1'b1);
        OP_EMIT:    ptr_q <= ptr_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers: quotient, remainder and output item.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        quot_q <= value_i;
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        quot_q <= quot_d;
        rem_q  <= rem_d;
      end
      OP_STORE: rem_q <= '0;
      OP_EMIT: begin
        char_q <= symbols_i[int'(rd_digit_q) * CHAR_W +: CHAR_W];
        last_q <= (ptr_q == '0);
      end
      default: ;
    endcase
  end

  // Digit store, least significant digit at entry zero.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_STORE) begin
      mem[count_q[IDX_W-1:0]] <= DIGIT_W'(rem_q);
    end
    if (op_i == OP_READ) begin
      rd_digit_q <= mem[ptr_q];
    end
  end

  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_o        = last_q;

endmodule

// ===== src/radix_integer_to_digits_top.sv =====
// Radix integer to digits.
//
// Converts one 64-bit unsigned value into its digits in a configured base
// (2 to 16), most significant digit first, one item per digit. Each digit is
// mapped to a symbol byte from a 16-entry table held in two registers.
// The configuration port takes radix (index 0), symbols_low (1) and
// symbols_high (2); the user must write them only while the block is idle,
// which the block itself does not enforce. Other indexes are ignored. An
// item is accepted at a clock edge with start high and busy low. Each digit
// is formed by divider steps of 8 quotient bits each plus one store, least
// significant digit first. Once all digits are stored they are read back
// most significant first, each by a digit store read plus a symbol lookup.
// No new item is taken until busy drops with the final digit.
// Each digit appears for one cycle on digit_valid_o; last_o marks the final
// one, which shows as busy drops. The receiver cannot stall the block.
// Reset returns the sequencer to idle and loads radix 10 and a zero table.
module radix_integer_to_digits_top
  import rid_pkg::*;
#(
  parameter int MAX_DIGITS = 64,
  parameter int MAX_RADIX  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VALUE_W-1:0]   cfg_wdata_i,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 busy,
  output logic                 digit_valid_o,
  output logic [CHAR_W-1:0]    digit_char_o,
  output logic                 last_o
);

  localparam int BASE_W = $clog2(MAX_RADIX + 1);

  logic [RADIX_W-1:0] radix_q;
  logic [VALUE_W-1:0] sym_low_q;
  logic [VALUE_W-1:0] sym_high_q;
  logic [BASE_W-1:0]  base;
  op_e                op;
  stat_t              stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_W'(10);
      sym_low_q  <= '0;
      sym_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RADIX:        radix_q    <= cfg_wdata_i[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  sym_low_q  <= cfg_wdata_i;
        REG_SYMBOLS_HIGH: sym_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the base into the supported range.
  always_comb begin
    priority if (radix_q < RADIX_W'(2)) begin
      base = BASE_W'(2);
    end else if (radix_q > RADIX_W'(MAX_RADIX)) begin
      base = BASE_W'(MAX_RADIX);
    end else begin
      base = BASE_W'(radix_q);
    end
  end

  rid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .op_o   (op),
    .busy   (busy)
  );

  rid_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .value_i       (value_i),
    .base_i        (base),
    .symbols_i     ({sym_high_q, sym_low_q}),
    .stat_o        (stat),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // An accepted item always starts a conversion.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start a conversion");

  // Digits are never emitted back to back.
  a_digit_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |=> !digit_valid_o)
    else $error("digits emitted in back-to-back cycles");

  // The final digit coincides with the return to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o && last_o |-> !busy)
    else $error("final digit emitted while still busy");

  // Any earlier digit leaves the block busy.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o && !last_o |-> busy)
    else $error("non-final digit emitted while idle");
`endif

endmodule
